>>> hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // scanner phase
   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_BODY = 2'd1,
      PH_ESC  = 2'd2,
      PH_HEX  = 2'd3
   } phase_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NO_OPEN_QUOTE = 3'd0,
      ERR_END_WAITING   = 3'd1,
      ERR_UNTERMINATED  = 3'd2,
      ERR_END_ESCAPE    = 3'd3,
      ERR_END_UNICODE   = 3'd4,
      ERR_BAD_HEX       = 3'd5,
      ERR_BAD_ESCAPE    = 3'd6
   } err_type;

   // characters of interest
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // utf-8 lead and continuation marks
   localparam logic [7:0] UTF_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF_CONT  = 8'h80;

   // scanner state between items
   typedef struct packed {
      phase_type   phase;
      logic [11:0] hex_acc;   // first three hex digits
      logic [1:0]  hex_cnt;
   } scan_type;

   // results caused by one item
   typedef struct packed {
      logic [1:0]       nres;
      kind_type         kind;
      err_type          code;
      logic [2:0][7:0]  bytes;  // bytes[0] goes out first
   } step_type;

   // hex digit value; bit 4 set means not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h37)};
      end
      return v;
   endfunction

endpackage

>>> hw/rtl/jsu_step.sv
// ----------------------------------------------------------------------------
// jsu_step
// Decodes one text byte against the scanner state: next state and the
// zero to three result transactions that the byte causes.
// ----------------------------------------------------------------------------
module jsu_step import jsu_pkg::*; (
   input  scan_type   cur,
   input  logic [7:0] text_byte,
   input  logic       text_ends,
   output scan_type   nxt,
   output step_type   res
);

   logic [4:0]  hex_v;
   logic [15:0] code_point;
   logic        esc_ok;
   logic [7:0]  esc_byte;

   assign hex_v      = hex_value(text_byte);
   assign code_point = {cur.hex_acc, hex_v[3:0]};

   // simple escape table
   always_comb begin
      esc_ok   = 1'b1;
      esc_byte = text_byte;
      case (text_byte)
         CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = text_byte;
         CH_LOW_B: esc_byte = 8'h08;
         CH_LOW_F: esc_byte = 8'h0C;
         CH_LOW_N: esc_byte = 8'h0A;
         CH_LOW_R: esc_byte = 8'h0D;
         CH_LOW_T: esc_byte = 8'h09;
         default:  esc_ok = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      nxt.phase   = PH_WAIT;
      nxt.hex_acc = '0;
      nxt.hex_cnt = '0;
      case (cur.phase)
         PH_BODY: begin
            if (text_ends || text_byte == CH_QUOTE) begin
               nxt.phase = PH_WAIT;
            end else if (text_byte == CH_BSLASH) begin
               nxt.phase = PH_ESC;
            end else begin
               nxt.phase = PH_BODY;
            end
         end
         PH_ESC: begin
            if (text_ends) begin
               nxt.phase = PH_WAIT;
            end else if (text_byte == CH_LOW_U) begin
               nxt.phase = PH_HEX;
            end else if (esc_ok) begin
               nxt.phase = PH_BODY;
            end else begin
               nxt.phase = PH_WAIT;
            end
         end
         PH_HEX: begin
            if (text_ends || hex_v[4]) begin
               nxt.phase = PH_WAIT;
            end else if (cur.hex_cnt != 2'd3) begin
               nxt.phase   = PH_HEX;
               nxt.hex_acc = {cur.hex_acc[7:0], hex_v[3:0]};
               nxt.hex_cnt = cur.hex_cnt + 2'd1;
            end else begin
               nxt.phase = PH_BODY;
            end
         end
         default: begin
            if (!text_ends && text_byte == CH_QUOTE) begin
               nxt.phase = PH_BODY;
            end else begin
               nxt.phase = PH_WAIT;
            end
         end
      endcase
   end

   // results
   always_comb begin
      res.nres  = 2'd0;
      res.kind  = KIND_BYTE;
      res.code  = ERR_NO_OPEN_QUOTE;
      res.bytes = '0;
      case (cur.phase)
         PH_BODY: begin
            if (text_ends) begin
               res.nres = 2'd1;
               res.kind = KIND_ERROR;
               res.code = ERR_UNTERMINATED;
            end else if (text_byte == CH_QUOTE) begin
               res.nres = 2'd1;
               res.kind = KIND_DONE;
            end else if (text_byte != CH_BSLASH) begin
               res.nres     = 2'd1;
               res.bytes[0] = text_byte;
            end
         end
         PH_ESC: begin
            if (text_ends) begin
               res.nres = 2'd1;
               res.kind = KIND_ERROR;
               res.code = ERR_END_ESCAPE;
            end else if (text_byte == CH_LOW_U) begin
               res.nres = 2'd0;
            end else if (esc_ok) begin
               res.nres     = 2'd1;
               res.bytes[0] = esc_byte;
            end else begin
               res.nres = 2'd1;
               res.kind = KIND_ERROR;
               res.code = ERR_BAD_ESCAPE;
            end
         end
         PH_HEX: begin
            if (text_ends) begin
               res.nres = 2'd1;
               res.kind = KIND_ERROR;
               res.code = ERR_END_UNICODE;
            end else if (hex_v[4]) begin
               res.nres = 2'd1;
               res.kind = KIND_ERROR;
               res.code = ERR_BAD_HEX;
            end else if (cur.hex_cnt == 2'd3) begin
               // utf-8 encoding of the collected code point
               if (code_point[15:7] == '0) begin
                  res.nres     = 2'd1;
                  res.bytes[0] = {1'b0, code_point[6:0]};
               end else if (code_point[15:11] == '0) begin
                  res.nres     = 2'd2;
                  res.bytes[0] = UTF_LEAD2 | {3'b000, code_point[10:6]};
                  res.bytes[1] = UTF_CONT | {2'b00, code_point[5:0]};
               end else begin
                  res.nres     = 2'd3;
                  res.bytes[0] = UTF_LEAD3 | {4'b0000, code_point[15:12]};
                  res.bytes[1] = UTF_CONT | {2'b00, code_point[11:6]};
                  res.bytes[2] = UTF_CONT | {2'b00, code_point[5:0]};
               end
            end
         end
         default: begin
            if (text_ends) begin
               res.nres = 2'd1;
               res.kind = KIND_ERROR;
               res.code = ERR_END_WAITING;
            end else if (text_byte != CH_QUOTE) begin
               res.nres = 2'd1;
               res.kind = KIND_ERROR;
               res.code = ERR_NO_OPEN_QUOTE;
            end
         end
      endcase
   end

endmodule

>>> hw/rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming JSON string unescaper with \uXXXX to UTF-8 conversion.
// ----------------------------------------------------------------------------
// Usage:
// - req channel carries one text byte per transaction, or an end-of-text
//   marker (req_text_ends high, byte ignored).
// - rsp channel carries decoded bytes, string-complete marks and errors;
//   rsp_last flags the final result caused by one request transaction.
// - each request is decoded in the cycle it is accepted and its results
//   sit in the result register from the next cycle.
// - a request that yields zero or one result leaves room for the next
//   request in the following cycle if the receiver takes any result, so
//   plain text streams at one byte per cycle while rsp_ready is high. A
//   \u escape that encodes to two or three UTF-8 bytes holds req_ready low
//   while the result register drains, one result per cycle when taken.
// - when the receiver stalls, req_ready falls once the result register
//   holds a result that cannot be handed on; nothing is dropped.
// - reset (synchronous, active high) empties the result register and
//   returns the scanner to waiting for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_text_ends,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   scan_type        scan_ff, scan_in;
   scan_type        scan_nxt;
   step_type        step_res;
   logic [1:0]      cnt_ff, cnt_in;
   kind_type        kind_ff, kind_in;
   err_type         code_ff, code_in;
   logic [2:0][7:0] byte_ff, byte_in;
   logic            req_take;
   logic            rsp_take;

   // per-byte decoder
   jsu_step u_step (
      .cur       (scan_ff),
      .text_byte (req_text_byte),
      .text_ends (req_text_ends),
      .nxt       (scan_nxt),
      .res       (step_res)
   );

   // handshakes
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign req_take  = req_valid && req_ready;

   // result register: load on request, shift out on response
   always_comb begin
      scan_in = scan_ff;
      cnt_in  = cnt_ff;
      kind_in = kind_ff;
      code_in = code_ff;
      byte_in = byte_ff;
      if (req_take) begin
         scan_in = scan_nxt;
         cnt_in  = step_res.nres;
         kind_in = step_res.kind;
         code_in = step_res.code;
         byte_in = step_res.bytes;
      end else if (rsp_take) begin
         cnt_in  = cnt_ff - 2'd1;
         byte_in = {8'h00, byte_ff[2], byte_ff[1]};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '{phase: PH_WAIT, hex_acc: '0, hex_cnt: '0};
         cnt_ff  <= 2'd0;
      end else begin
         scan_ff <= scan_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      code_ff <= code_in;
      byte_ff <= byte_in;
   end

   // outputs
   assign rsp_result_kind = kind_ff;
   assign rsp_out_byte    = byte_ff[0];
   assign rsp_error_code  = code_ff;
   assign rsp_last        = (cnt_ff == 2'd1);

endmodule

>>> hw/rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_text_byte,
   input logic       req_text_ends,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_result_kind,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_error_code,
   input logic       rsp_last
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_out_byte) && $stable(rsp_error_code) && $stable(rsp_last))
      else $error("result changed while stalled");

   // completion and error results always stand alone
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_BYTE |-> rsp_last)
      else $error("non-byte result not last");

   // byte field is zero outside byte results
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_BYTE |-> rsp_out_byte == 8'h00)
      else $error("stray byte on non-byte result");

   // error field is zero outside error results
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_ERROR |-> rsp_error_code == 3'd0)
      else $error("stray error code");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);
